### rtl/core/ast_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm state table package
// Shared field widths, request codes and the structs that pass between the
// table controller and the match unit.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned STATE_W = 8;

  // An id of zero marks a free slot.
  localparam logic [ID_W-1:0] FREE_ID = 8'h00;

  // Request codes.
  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  // One table entry as it is stored in the memory.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STATE_W-1:0] state;
  } ast_entry_t;

  // Controls from the sequencer to the match unit.
  typedef struct packed {
    logic clear;   // start of a new request
    logic cmp_en;  // read data of the scanned entry is present
  } ast_scan_ctl_t;

  // Summary of a finished scan.
  typedef struct packed {
    logic               hit;        // some entry holds the key
    logic               free_hit;   // some entry is free
    logic [STATE_W-1:0] hit_state;  // state of the first matching entry
  } ast_scan_res_t;

endpackage

### rtl/core/ast_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm state table channels
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface ast_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [ast_pkg::ID_W-1:0]    alarm_id;
  logic [ast_pkg::STATE_W-1:0] new_state;

  modport source (output valid, output op, output alarm_id, output new_state,
                  input ready);
  modport sink   (input valid, input op, input alarm_id, input new_state,
                  output ready);
endinterface

interface ast_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  logic [ast_pkg::STATE_W-1:0] state_out;

  modport source (output valid, output success, output state_out, input ready);
  modport sink   (input valid, input success, input state_out, output ready);
endinterface

### rtl/core/alarm_state_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm state table
// Associative table of alarm ids and states with set and get requests.
// ----------------------------------------------------------------------------
// Each request passes through four states: S_IDLE takes the beat, S_SCAN
// reads every slot in turn through the single read port of the table
// memory, S_WAIT compares the last read data, and S_FINISH writes the entry
// back and loads the response. The write-back in S_FINISH waits for as long
// as the output register still holds a response the sink has not taken.
// A new request is taken as soon as the previous one has left its
// response in the output register, even while that response still waits
// for the sink. The table reads as all free after
// reset with no clearing pass: a flip-flop per entry marks it as written, and
// an unwritten entry reads as id 0, state 0. A set claims the first free slot
// when its id is absent and fails when the table is full; id 0 matches the
// first free slot for both set and get.
module alarm_state_table_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ast_req_if.sink   req_i,
  ast_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W   = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int unsigned ENTRY_W = $bits(ast_pkg::ast_entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_FINISH
  } state_e;

  state_e                      state_q;
  logic [IDX_W-1:0]            addr_q;
  logic                        rd_vld_q;
  logic [IDX_W-1:0]            rd_idx_q;
  logic                        op_q;
  logic [ast_pkg::ID_W-1:0]    id_q;
  logic [ast_pkg::STATE_W-1:0] st_q;
  logic                        out_valid_q;
  logic                        out_success_q;
  logic [ast_pkg::STATE_W-1:0] out_state_q;
  logic [ENTRIES-1:0]          written_q;

  logic                   req_fire;
  logic                   out_free;
  logic                   finish;
  logic                   set_ok;
  logic                   ram_we;
  logic                   ram_re;
  logic [ENTRY_W-1:0]     ram_rdata;
  ast_pkg::ast_entry_t    ram_wentry;
  ast_pkg::ast_entry_t    rd_entry;
  ast_pkg::ast_scan_ctl_t scan_ctl;
  ast_pkg::ast_scan_res_t scan_res;
  logic [IDX_W-1:0]       wr_idx;

  // Handshake and write-back conditions.
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid & req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign finish      = (state_q == S_FINISH) && out_free;
  assign set_ok      = scan_res.hit || scan_res.free_hit;
  assign ram_we      = finish && (op_q == ast_pkg::OP_SET) && set_ok;
  assign ram_re      = (state_q == S_SCAN);

  // Sequencer, scan address and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      addr_q        <= '0;
      rd_vld_q      <= 1'b0;
      rd_idx_q      <= '0;
      op_q          <= ast_pkg::OP_SET;
      id_q          <= '0;
      st_q          <= '0;
      out_valid_q   <= 1'b0;
      out_success_q <= 1'b0;
      out_state_q   <= '0;
    end else begin
      rd_vld_q <= ram_re;
      rd_idx_q <= addr_q;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            op_q    <= req_i.op;
            id_q    <= req_i.alarm_id;
            st_q    <= req_i.new_state;
            addr_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (addr_q == LAST_IDX) begin
            state_q <= S_WAIT;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        S_WAIT: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            if (op_q == ast_pkg::OP_SET) begin
              out_success_q <= set_ok;
              out_state_q   <= '0;
            end else begin
              out_success_q <= scan_res.hit;
              out_state_q   <= scan_res.hit ? scan_res.hit_state : '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Per-entry written marks; an unwritten entry reads as free with state 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (ram_we) begin
      written_q[wr_idx] <= 1'b1;
    end
  end

  assign rd_entry = written_q[rd_idx_q] ? ast_pkg::ast_entry_t'(ram_rdata) : '0;

  assign ram_wentry.id    = id_q;
  assign ram_wentry.state = st_q;

  // Table memory.
  ast_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx),
    .wdata_i (ram_wentry),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // Match tracking over the scan.
  assign scan_ctl.clear  = req_fire;
  assign scan_ctl.cmp_en = rd_vld_q;

  ast_match #(
    .ENTRIES (ENTRIES)
  ) u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .key_i      (id_q),
    .rd_entry_i (rd_entry),
    .rd_idx_i   (rd_idx_q),
    .res_o      (scan_res),
    .wr_idx_o   (wr_idx)
  );

  // Response channel.
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.success   = out_success_q;
  assign rsp_o.state_out = out_state_q;

`ifndef SYNTHESIS
  // A taken request always starts a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == S_SCAN)
    else $error("accepted request did not start a scan");

  // The table is written back only at the end of a set request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_FINISH) && (op_q == ast_pkg::OP_SET))
    else $error("table write outside a set write-back");

  // Read data is compared only while the scan is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_SCAN) || (state_q == S_WAIT))
    else $error("entry compare outside the scan");

  // A failed lookup never reports a state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_success_q) |-> (out_state_q == '0))
    else $error("failed response carries a nonzero state");
`endif

endmodule

### rtl/core/ast_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ast_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/core/ast_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm state table match unit
// Watches the entries as the scan reads them and keeps the first entry that
// holds the key and the first free entry.
// ----------------------------------------------------------------------------
module ast_match #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  ast_pkg::ast_scan_ctl_t                        ctl_i,
  input  logic [ast_pkg::ID_W-1:0]                      key_i,
  input  ast_pkg::ast_entry_t                           rd_entry_i,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_idx_i,
  output ast_pkg::ast_scan_res_t                        res_o,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_idx_o
);

  localparam int unsigned IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

  logic                        hit_q;
  logic [IDX_W-1:0]            hit_idx_q;
  logic [ast_pkg::STATE_W-1:0] hit_state_q;
  logic                        free_q;
  logic [IDX_W-1:0]            free_idx_q;

  // Keep only the first match and the first free slot in scan order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_state_q <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
    end else if (ctl_i.clear) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      if (!hit_q && (rd_entry_i.id == key_i)) begin
        hit_q       <= 1'b1;
        hit_idx_q   <= rd_idx_i;
        hit_state_q <= rd_entry_i.state;
      end
      if (!free_q && (rd_entry_i.id == ast_pkg::FREE_ID)) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_i;
      end
    end
  end

  // An update goes to the matching entry, otherwise to the first free one.
  assign wr_idx_o        = hit_q ? hit_idx_q : free_idx_q;
  assign res_o.hit       = hit_q;
  assign res_o.free_hit  = free_q;
  assign res_o.hit_state = hit_state_q;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm state table testbench
// Drives set and get requests into the table and checks every response beat
// against a shadow copy of the table. The stimulus opens with a directed run
// over free-slot, miss, update and allocation cases. It then runs random
// traffic that fills the table slowly and ends on a full table. The request
// side sends in bursts with gaps. The response side stalls on its own
// pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned ID_W         = ast_pkg::ID_W;
  localparam int unsigned STATE_W      = ast_pkg::STATE_W;
  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned LIMIT_CYCLES = 400_000;
  localparam int unsigned HOLD_AFTER   = 600;
  localparam int unsigned HOLD_CYCLES  = 400;

  // One response beat as the table should produce it.
  typedef struct packed {
    logic               success;
    logic [STATE_W-1:0] state;
  } rsp_beat_t;

  // Shadow of the table contents plus the responses still owed by the block.
  class alarm_table_shadow;
    logic [ID_W-1:0]    slot_id    [TABLE_DEPTH];
    logic [STATE_W-1:0] slot_state [TABLE_DEPTH];
    rsp_beat_t          awaited_rsp[$];
    int unsigned        errors;

    function new();
      foreach (slot_id[i]) begin
        slot_id[i]    = ast_pkg::FREE_ID;
        slot_state[i] = '0;
      end
      errors = 0;
    endfunction

    // First slot holding the id, or TABLE_DEPTH when there is none.
    function int unsigned find_slot(logic [ID_W-1:0] id);
      for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
        if (slot_id[i] == id) return i;
      end
      return TABLE_DEPTH;
    endfunction

    // Apply an accepted request to the shadow and queue its response.
    function void take_request(logic op, logic [ID_W-1:0] id,
                               logic [STATE_W-1:0] st);
      int unsigned hit;
      int unsigned spare;
      rsp_beat_t   rsp;
      hit = find_slot(id);
      rsp = '0;
      if (op == ast_pkg::OP_SET) begin
        if (hit < TABLE_DEPTH) begin
          slot_state[hit] = st;
          rsp.success     = 1'b1;
        end else begin
          // Absent id: claim the first free slot, or fail on a full table.
          spare = find_slot(ast_pkg::FREE_ID);
          if (spare < TABLE_DEPTH) begin
            slot_id[spare]    = id;
            slot_state[spare] = st;
            rsp.success       = 1'b1;
          end
        end
      end else if (hit < TABLE_DEPTH) begin
        rsp.success = 1'b1;
        rsp.state   = slot_state[hit];
      end
      awaited_rsp = {awaited_rsp, rsp};
    endfunction

    // Compare a response beat with the oldest owed response.
    function void check_response(logic success, logic [STATE_W-1:0] st);
      rsp_beat_t want;
      if (awaited_rsp.size() == 0) begin
        $error("response beat with no request outstanding");
        errors++;
        return;
      end
      want = awaited_rsp.pop_front();
      if (success !== want.success) begin
        $error("success mismatch: expected %0d, actual %0d", want.success, success);
        errors++;
      end
      if (st !== want.state) begin
        $error("state_out mismatch: expected 0x%02h, actual 0x%02h", want.state, st);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited_rsp.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic hold_rsp;

  int unsigned       rsp_beats;
  int unsigned       burst_left;
  int unsigned       cycle_count;
  logic [ID_W-1:0]   issued_ids[$];
  alarm_table_shadow shadow;

  ast_req_if req ();
  ast_rsp_if rsp ();

  alarm_state_table_unit #(
    .ENTRIES(TABLE_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req.sink),
    .rsp_o (rsp.source)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // Beat monitor: values read here are those present just before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        shadow.check_response(rsp.success, rsp.state_out);
        rsp_beats++;
      end
      if (req.valid && req.ready) begin
        shadow.take_request(req.op, req.alarm_id, req.new_state);
      end
    end
  end

  // One long hold-off on the response side while requests keep coming.
  initial begin
    hold_rsp <= 1'b0;
    wait (rsp_beats >= HOLD_AFTER);
    @(posedge clk_i);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rsp <= 1'b0;
  end

  // Response-side stall pattern: spans of always-ready, random and periodic.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    logic        go;
    rsp.ready <= 1'b0;
    tick = 0;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(50, 300);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        case (mode)
          0: go = 1'b1;
          1: go = ($urandom_range(0, 9) < 7);
          2: go = ((tick % 7) < 3);
          default: go = ($urandom_range(0, 9) < 3);
        endcase
        rsp.ready <= go && !hold_rsp;
      end
    end
  end

  // Send one request beat. Bursts keep valid high; a burst end may add a gap.
  task automatic send_request(input logic op, input logic [ID_W-1:0] id,
                              input logic [STATE_W-1:0] st);
    int unsigned gap;
    req.valid     <= 1'b1;
    req.op        <= op;
    req.alarm_id  <= id;
    req.new_state <= st;
    if (op == ast_pkg::OP_SET && id != ast_pkg::FREE_ID) issued_ids = {issued_ids, id};
    do @(posedge clk_i); while (!req.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        9:          gap = $urandom_range(30, 60);
        default:    gap = $urandom_range(1, 25);
      endcase
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Free slot, miss, allocation and update cases on a table that is not full.
  task automatic run_directed();
    send_request(ast_pkg::OP_GET, ast_pkg::FREE_ID, 8'h00);
    send_request(ast_pkg::OP_GET, 8'hFF, 8'h00);
    send_request(ast_pkg::OP_SET, ast_pkg::FREE_ID, 8'hAB);
    send_request(ast_pkg::OP_GET, ast_pkg::FREE_ID, 8'hFF);
    send_request(ast_pkg::OP_SET, 8'hFF, 8'hFF);
    send_request(ast_pkg::OP_GET, ast_pkg::FREE_ID, 8'h00);
    send_request(ast_pkg::OP_GET, 8'hFF, 8'h00);
    send_request(ast_pkg::OP_SET, 8'hFF, 8'h00);
    send_request(ast_pkg::OP_GET, 8'hFF, 8'hFF);
    send_request(ast_pkg::OP_SET, 8'h01, 8'h5A);
    send_request(ast_pkg::OP_GET, 8'h01, 8'h00);
    send_request(ast_pkg::OP_SET, 8'h80, 8'hA5);
    send_request(ast_pkg::OP_GET, 8'h80, 8'h00);
    send_request(ast_pkg::OP_GET, 8'h7F, 8'h00);
    send_request(ast_pkg::OP_SET, 8'h01, 8'hFF);
    send_request(ast_pkg::OP_GET, 8'h01, 8'h00);
  endtask

  // Random traffic: mostly requests on ids already used, with rare new ids
  // early on and frequent ones near the end so that the table fills up.
  task automatic run_random(input int unsigned count);
    int unsigned       roll;
    int unsigned       alloc_pct;
    logic              op;
    logic [ID_W-1:0]   id;
    logic [STATE_W-1:0] st;
    for (int unsigned i = 0; i < count; i++) begin
      roll      = $urandom_range(0, 99);
      alloc_pct = (i < (count * 3) / 4) ? 1 : 20;
      op        = 1'($urandom_range(0, 1));
      st        = STATE_W'($urandom_range(0, 255));
      if (roll < alloc_pct) begin
        op = ast_pkg::OP_SET;
        id = ID_W'($urandom_range(1, 255));
      end else if (roll < alloc_pct + 6) begin
        id = ast_pkg::FREE_ID;
      end else if (roll < alloc_pct + 16 || issued_ids.size() == 0) begin
        op = ast_pkg::OP_GET;
        id = ID_W'($urandom_range(0, 255));
      end else begin
        id = issued_ids[$urandom_range(0, issued_ids.size() - 1)];
      end
      send_request(op, id, st);
    end
  endtask

  // Main sequence.
  initial begin
    shadow        = new();
    rsp_beats     = 0;
    burst_left    = 0;
    rst_ni        = 1'b0;
    req.valid     <= 1'b0;
    req.op        <= ast_pkg::OP_SET;
    req.alarm_id  <= ast_pkg::FREE_ID;
    req.new_state <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(RANDOM_ITEMS);
    req.valid <= 1'b0;

    // Drain the owed responses, then let the block settle.
    while (shadow.outstanding() != 0) @(posedge clk_i);
    repeat (2 * TABLE_DEPTH + 8) @(posedge clk_i);

    if (shadow.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
